// ===== src/pressure_frame_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// pressure_frame_parser_top_macros.svh
// Assertion macros for the pressure frame parser. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_FRAME_PARSER_TOP_MACROS_SVH
`define PRESSURE_FRAME_PARSER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFP_ASSERT(lbl, prop, msg)
`define PFP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared constants, types and helpers of the pressure frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int PAYLOAD_LEN = 7;
  localparam int FILL_W      = 3;
  localparam int CHAR_W      = 8;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t START_MARK = 8'h3B;  // ';'
  localparam char_t END_MARK   = 8'h3A;  // ':'
  localparam char_t SEP_MARK   = 8'h78;  // 'x'
  localparam char_t DIGIT_LO   = 8'h30;
  localparam char_t DIGIT_HI   = 8'h39;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(PAYLOAD_LEN);

  typedef logic [PAYLOAD_LEN-1:0][CHAR_W-1:0] text_t;

  // "#ERROR#", element 0 is the first character
  localparam text_t ERROR_TEXT = {8'h23, 8'h52, 8'h4F, 8'h52, 8'h52, 8'h45, 8'h23};

  typedef struct packed {
    logic  frame_error;
    text_t text;
  } pfp_res_t;

  typedef struct packed {
    logic              awaiting;
    logic [FILL_W-1:0] fill;
  } pfp_stat_t;

  function automatic logic is_digit(input char_t c);
    return (c >= DIGIT_LO) && (c <= DIGIT_HI);
  endfunction

endpackage

// ===== src/pressure_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// pressure_frame_parser_top
// Frames blood-pressure readings from a serial byte stream.
//
// Input channel: one ASCII byte per transaction on in_rx_byte (in_valid,
// in_stall). Result channel: out_frame_error and out_text_byte_0..6
// (out_valid, out_stall). A frame is ';', seven payload bytes, ':'. A valid
// payload (three digits, 'x', three digits) is passed on with the error flag
// low; any malformed frame gives "#ERROR#" with the flag high.
// A result passes the input register, then the result register, after the
// byte that closes the frame is accepted. Throughput: one byte per cycle
// unless a result meets a full, stalled result register; the frame check
// and state update fit in the single stage between the two registers.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to waiting for ';'.
// A stalled result holds; bytes that cause no result keep flowing, and
// in_stall rises only when a result-producing byte meets a full, stalled
// result register.
// ----------------------------------------------------------------------------
`include "pressure_frame_parser_top_macros.svh"

module pressure_frame_parser_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfp_pkg::char_t in_rx_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_frame_error,
  output pfp_pkg::char_t out_text_byte_0,
  output pfp_pkg::char_t out_text_byte_1,
  output pfp_pkg::char_t out_text_byte_2,
  output pfp_pkg::char_t out_text_byte_3,
  output pfp_pkg::char_t out_text_byte_4,
  output pfp_pkg::char_t out_text_byte_5,
  output pfp_pkg::char_t out_text_byte_6
);
  import pfp_pkg::*;

  logic      a_vld;
  char_t     a_byte;
  logic      a_take;
  logic      out_ready;
  logic      res_vld;
  pfp_res_t  res;
  pfp_res_t  out_res;
  pfp_stat_t stat;

  pfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .a_take     (a_take),
    .a_vld      (a_vld),
    .a_byte     (a_byte)
  );

  pfp_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_vld     (a_vld),
    .a_byte    (a_byte),
    .out_ready (out_ready),
    .a_take    (a_take),
    .res_vld   (res_vld),
    .res       (res),
    .stat      (stat)
  );

  pfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_frame_error = out_res.frame_error;
  assign out_text_byte_0 = out_res.text[0];
  assign out_text_byte_1 = out_res.text[1];
  assign out_text_byte_2 = out_res.text[2];
  assign out_text_byte_3 = out_res.text[3];
  assign out_text_byte_4 = out_res.text[4];
  assign out_text_byte_5 = out_res.text[5];
  assign out_text_byte_6 = out_res.text[6];

  `PFP_ASSERT(a_idle_no_fill, stat.awaiting |-> (stat.fill == '0), "fill count set while idle")
  `PFP_ASSERT(a_res_from_byte, $rose(out_valid) |-> $past(a_take), "result without a byte taken")
  `PFP_ASSERT(a_valid_sep, (out_valid && !out_frame_error) |-> (out_text_byte_3 == SEP_MARK), "valid reading without separator")
  `PFP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (stat.awaiting && !out_valid), "reset did not return to idle")

endmodule

// ===== src/pfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// pfp_in_reg
// Input register: holds one received byte until the frame stage takes it.
// ----------------------------------------------------------------------------
module pfp_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pfp_pkg::char_t in_rx_byte,
  output logic          in_stall,
  input  logic          a_take,
  output logic          a_vld,
  output pfp_pkg::char_t a_byte
);
  import pfp_pkg::*;

  logic  vld_r, vld_nxt;
  char_t byte_r;
  logic  in_fire;

  assign in_stall = vld_r && !a_take;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (in_fire) begin
      vld_nxt = 1'b1;
    end else if (a_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_rx_byte;
    end
  end

  assign a_vld  = vld_r;
  assign a_byte = byte_r;

endmodule

// ===== src/pfp_frame.sv =====
// ----------------------------------------------------------------------------
// pfp_frame
// Frame state, payload store and format check; forms one result per frame.
// ----------------------------------------------------------------------------
module pfp_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              a_vld,
  input  pfp_pkg::char_t    a_byte,
  input  logic              out_ready,
  output logic              a_take,
  output logic              res_vld,
  output pfp_pkg::pfp_res_t res,
  output pfp_pkg::pfp_stat_t stat
);
  import pfp_pkg::*;

  logic              awaiting_r, awaiting_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  char_t             store_r [PAYLOAD_LEN];
  logic              gen;
  logic              err;
  logic              store_en;
  logic              payload_ok;
  text_t             payload;

  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload[i] = store_r[i];
    end
  end

  assign payload_ok = (store_r[3] == SEP_MARK) &&
                      is_digit(store_r[0]) && is_digit(store_r[1]) &&
                      is_digit(store_r[2]) && is_digit(store_r[4]) &&
                      is_digit(store_r[5]) && is_digit(store_r[6]);

  always_comb begin
    gen          = 1'b0;
    err          = 1'b1;
    store_en     = 1'b0;
    awaiting_nxt = awaiting_r;
    fill_nxt     = fill_r;
    if (awaiting_r) begin
      if (a_byte == START_MARK) begin
        awaiting_nxt = 1'b0;
      end
    end else if (fill_r == FILL_FULL) begin
      gen          = 1'b1;
      err          = !((a_byte == END_MARK) && payload_ok);
      awaiting_nxt = 1'b1;
      fill_nxt     = '0;
    end else if (a_byte == END_MARK) begin
      gen          = 1'b1;
      awaiting_nxt = 1'b1;
      fill_nxt     = '0;
    end else if (a_byte == START_MARK) begin
      gen      = 1'b1;
      fill_nxt = '0;
    end else begin
      store_en = 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
  end

  assign a_take  = a_vld && (!gen || out_ready);
  assign res_vld = a_take && gen;

  assign res.frame_error = err;
  assign res.text        = err ? ERROR_TEXT : payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b1;
      fill_r     <= '0;
    end else if (a_take) begin
      awaiting_r <= awaiting_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && store_en) begin
      store_r[fill_r] <= a_byte;
    end
  end

  assign stat.awaiting = awaiting_r;
  assign stat.fill     = fill_r;

endmodule

// ===== src/pfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// pfp_out_reg
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module pfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_vld,
  input  pfp_pkg::pfp_res_t res,
  input  logic              out_stall,
  output logic              out_ready,
  output logic              out_valid,
  output pfp_pkg::pfp_res_t out_res
);
  import pfp_pkg::*;

  logic     vld_r, vld_nxt;
  pfp_res_t res_r;

  assign out_ready = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ===== sim/pressure_frame_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// pressure_frame_parser_top_tb
// Self-checking bench for the pressure frame parser. A scoreboard follows the
// frame state byte by byte and predicts each reading or error text. A short
// directed sequence is followed by random frames, both well-formed and
// broken. Random gaps on the input side and random stalls on the result side
// vary by phase. One phase holds the result side off long enough to back the
// block up.
// ----------------------------------------------------------------------------
module pressure_frame_parser_top_tb;
  import pfp_pkg::*;

  class reading_scoreboard;
    pfp_res_t expected_readings[$];
    bit       hunting;
    logic [FILL_W-1:0] collected;
    text_t    payload;
    int       errors;

    function new();
      hunting   = 1'b1;
      collected = '0;
      payload   = '0;
      errors    = 0;
    endfunction

    static function bit numeric(char_t c);
      return (c >= DIGIT_LO) && (c <= DIGIT_HI);
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void note_byte(char_t b);
      pfp_res_t r;
      bit ok;
      r.frame_error = 1'b1;
      r.text        = ERROR_TEXT;
      if (hunting) begin
        if (b == START_MARK) hunting = 1'b0;
        return;
      end
      if (collected == FILL_FULL) begin
        ok = (b == END_MARK) && (payload[3] == SEP_MARK);
        for (int i = 0; i < 3; i++) begin
          if (!numeric(payload[i]) || !numeric(payload[i+4])) ok = 1'b0;
        end
        if (ok) begin
          r.frame_error = 1'b0;
          r.text        = payload;
        end
        expected_readings.push_back(r);
        hunting   = 1'b1;
        collected = '0;
      end else if (b == END_MARK) begin
        expected_readings.push_back(r);
        hunting   = 1'b1;
        collected = '0;
      end else if (b == START_MARK) begin
        expected_readings.push_back(r);
        collected = '0;
      end else begin
        payload[collected] = b;
        collected = collected + 1'b1;
      end
    endfunction

    function void check_reading(pfp_res_t got);
      pfp_res_t exp;
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: frame_error %0d, text %h", got.frame_error, got.text);
        errors++;
        return;
      end
      exp = expected_readings.pop_front();
      if (got.frame_error !== exp.frame_error) begin
        $error("frame_error: expected %0d, actual %0d", exp.frame_error, got.frame_error);
        errors++;
      end
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        if (got.text[i] !== exp.text[i]) begin
          $error("text_byte_%0d: expected %h, actual %h", i, exp.text[i], got.text[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  char_t in_rx_byte;
  logic  out_valid;
  logic  out_stall;
  logic  out_frame_error;
  char_t out_text_byte_0;
  char_t out_text_byte_1;
  char_t out_text_byte_2;
  char_t out_text_byte_3;
  char_t out_text_byte_4;
  char_t out_text_byte_5;
  char_t out_text_byte_6;

  reading_scoreboard sb = new();

  int    tx_max_gap  = 0;
  int    rx_max_wait = 0;
  bit    hold_go     = 1'b0;
  bit    hold_long   = 1'b0;
  char_t frame_bytes[$];

  pressure_frame_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_error (out_frame_error),
    .out_text_byte_0 (out_text_byte_0),
    .out_text_byte_1 (out_text_byte_1),
    .out_text_byte_2 (out_text_byte_2),
    .out_text_byte_3 (out_text_byte_3),
    .out_text_byte_4 (out_text_byte_4),
    .out_text_byte_5 (out_text_byte_5),
    .out_text_byte_6 (out_text_byte_6)
  );

  always #1 clk = ~clk;

  function automatic char_t numeral();
    return char_t'(DIGIT_LO + $urandom_range(0, 9));
  endfunction

  function automatic void build_frame();
    int    kind;
    int    n;
    char_t body[PAYLOAD_LEN];
    kind = $urandom_range(0, 15);
    for (int i = 0; i < PAYLOAD_LEN; i++) body[i] = (i == 3) ? SEP_MARK : numeral();
    frame_bytes.delete();
    frame_bytes.push_back(START_MARK);
    case (kind)
      9:  body[$urandom_range(0, 6)] = char_t'($urandom);
      10: begin
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
          0: body[n] = DIGIT_LO - 1'b1;
          1: body[n] = DIGIT_HI + 3'd7;
          2: body[n] = SEP_MARK - 6'd32;
          default: body[n] = SEP_MARK + 1'b1;
        endcase
      end
      11: for (int i = 0; i < PAYLOAD_LEN; i++) body[i] = char_t'($urandom);
      12: begin
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) frame_bytes.push_back(body[i]);
        frame_bytes.push_back($urandom_range(0, 1) ? END_MARK : START_MARK);
        return;
      end
      default: ;
    endcase
    for (int i = 0; i < PAYLOAD_LEN; i++) frame_bytes.push_back(body[i]);
    if (kind == 13) frame_bytes.push_back(char_t'($urandom));
    else if (kind == 14) frame_bytes.push_back(START_MARK);
    else frame_bytes.push_back(END_MARK);
  endfunction

  task automatic send_byte(input char_t b);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() != 0) begin
      $error("%0d readings never arrived", sb.pending());
      sb.errors++;
    end
  endtask

  // result side: stall pattern at negedge, transaction check at posedge
  initial begin : result_sink
    int       stall_left;
    pfp_res_t got;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_long || (stall_left != 0);
      if (stall_left != 0) stall_left--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.frame_error = out_frame_error;
        got.text = {out_text_byte_6, out_text_byte_5, out_text_byte_4, out_text_byte_3,
                    out_text_byte_2, out_text_byte_1, out_text_byte_0};
        sb.check_reading(got);
        stall_left = $urandom_range(0, rx_max_wait);
      end
    end
  end

  // long back-pressure stretch
  initial begin : long_hold
    wait (hold_go);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  initial begin : timeout
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    char_t opening[$];
    int    sent;
    opening = '{8'h00, START_MARK, "1", "2", START_MARK,
                "0", "0", "0", "x", "9", "9", "9", END_MARK,
                START_MARK, "9", "@", "9", "x", "0", "/", 8'hFF, END_MARK,
                START_MARK, END_MARK};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_max_gap  = 3;
    rx_max_wait = 3;
    foreach (opening[i]) send_byte(opening[i]);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin tx_max_gap = 17; rx_max_wait = 17; end
        1: begin tx_max_gap = 0;  rx_max_wait = 0;  end
        2: begin tx_max_gap = 0;  rx_max_wait = 4;  hold_go = 1'b1; end
        3: begin tx_max_gap = 17; rx_max_wait = 0;  end
        default: begin tx_max_gap = 2; rx_max_wait = 17; end
      endcase
      sent = 0;
      while (sent < 140) begin
        // line noise between frames
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(char_t'($urandom));
        end
        build_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        sent += frame_bytes.size();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
